// ===== design/timestamped_position_history_interp_macros.svh =====
// Assertion macros shared by the checker
`ifndef TIMESTAMPED_POSITION_HISTORY_INTERP_MACROS_SVH
`define TIMESTAMPED_POSITION_HISTORY_INTERP_MACROS_SVH
// implication checked on every clock, skipped while in reset
`define TPH_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TPH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/tph_pkg.sv =====
// ----------------------------------------------------------------------------
// tph_pkg
// Shared types and constants of the position history block.
// ----------------------------------------------------------------------------
package tph_pkg;
    localparam int TIME_W   = 32;
    localparam int CTR_W    = 32;
    localparam int EXT_W    = 31;
    localparam int SAMPLE_W = TIME_W + 3 * CTR_W + 3 * EXT_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSEEN  = 2'd1;
    localparam logic [1:0] ST_NOBRKT  = 2'd2;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef struct packed {
        logic [EXT_W-1:0]  ez;
        logic [EXT_W-1:0]  ey;
        logic [EXT_W-1:0]  ex;
        logic [CTR_W-1:0]  cz;
        logic [CTR_W-1:0]  cy;
        logic [CTR_W-1:0]  cx;
        logic [TIME_W-1:0] ts;
    } sample_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_SCAN, S_FETCH_LO, S_FETCH_HI, S_LATCH,
        S_MUL, S_DIV, S_NEXT_AXIS, S_OUT
    } state_t;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;
endpackage

// ===== design/timestamped_position_history_interp.sv =====
// ----------------------------------------------------------------------------
// timestamped_position_history_interp
// Per-target sample rings with linearly interpolated position queries.
// ----------------------------------------------------------------------------
// After reset the block clears its sample memory, one slot a cycle, over
// TARGETS times DEPTH (rounded up to a power of two) slots, taking no word
// meanwhile. A record word is written to the target's ring in S_READ. A query
// walks the target's ring through one memory port, one slot a cycle, fetches
// the two bracketing samples, then per axis runs one 32x32 multiply and a
// serial division. On an exact time hit the multiply and division are
// skipped; an unknown target is answered from S_READ and a missing bracket
// right after the scan. The result register frees the input side once the
// word has been taken.
module timestamped_position_history_interp #(
    parameter int DEPTH   = 128,
    parameter int TARGETS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[0], target[4:1], timestamp[36:5], center_x/y/z[132:37],
    // extent_x/y/z[225:133], zero pad to 232
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], out_center_x/y/z[97:2], out_extent_x/y/z[190:98], pad to 192
    output logic [191:0] m_tdata
);
    import tph_pkg::*;

    localparam int SW  = $clog2(DEPTH);
    localparam int TW  = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    // each ring gets a power-of-two region so {target, slot} is the address
    localparam int WORDS = TARGETS * (2 ** SW);
    localparam int AW  = $clog2(WORDS);

    state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [SW-1:0]   slot_reg [TARGETS];
    logic [TARGETS-1:0] seen_reg;
    logic [231:0] in_reg, in_next;
    logic [SW:0]  idx_reg, idx_next;
    logic [SW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [TIME_W-1:0] lot_reg, lot_next, hit_reg, hit_next;
    logic have_lo_reg, have_lo_next, have_hi_reg, have_hi_next;
    sample_t lo_s_reg, lo_s_next, hi_s_reg, hi_s_next;
    logic [1:0]  axis_reg, axis_next;
    logic [63:0] prod_reg, prod_next;
    logic        neg_reg, neg_next;
    logic [CTR_W-1:0] res_c_reg [3];
    logic [CTR_W-1:0] res_c_next [3];
    logic [191:0] out_reg, out_next;
    logic         ovalid_reg, ovalid_next;

    logic          we;
    logic [AW-1:0] addr;
    sample_t       wdata, rdata;
    div_req_t      dreq;
    logic          ddone;
    logic [63:0]   dquot;

    tph_ram #(.WIDTH(SAMPLE_W), .DEPTH(WORDS)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    tph_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quot(dquot));

    logic [3:0]       in_tg;
    logic [TIME_W-1:0] in_t;
    logic             tg_ok;
    logic [TW-1:0]    tg;
    sample_t          in_s;
    logic [TIME_W-1:0] num, den;
    logic signed [CTR_W:0] diff;
    logic [CTR_W:0]   mag;
    logic [CTR_W-1:0] lo_c, hi_c;
    logic [CTR_W-1:0] off;

    assign in_tg = in_reg[4:1];
    assign in_t  = in_reg[36:5];
    assign tg_ok = ({28'd0, in_tg} < 32'(TARGETS));
    assign tg    = TW'(in_tg);
    assign in_s  = {in_reg[225:133], in_reg[132:37], in_t};
    assign num   = in_t - lot_reg;
    assign den   = hit_reg - lot_reg;

    always_comb begin
        case (axis_reg)
            2'd0:    begin lo_c = lo_s_reg.cx; hi_c = hi_s_reg.cx; end
            2'd1:    begin lo_c = lo_s_reg.cy; hi_c = hi_s_reg.cy; end
            default: begin lo_c = lo_s_reg.cz; hi_c = hi_s_reg.cz; end
        endcase
        diff = $signed({hi_c[CTR_W-1], hi_c}) - $signed({lo_c[CTR_W-1], lo_c});
        mag  = diff[CTR_W] ? (CTR_W+1)'(0) - diff : diff;
        off  = neg_reg ? CTR_W'(0) - dquot[CTR_W-1:0] : dquot[CTR_W-1:0];
    end

    always_comb begin
        state_next = state_reg; clr_next = clr_reg; in_next = in_reg;
        idx_next = idx_reg; lo_next = lo_reg; hi_next = hi_reg;
        lot_next = lot_reg; hit_next = hit_reg;
        have_lo_next = have_lo_reg; have_hi_next = have_hi_reg;
        lo_s_next = lo_s_reg; hi_s_next = hi_s_reg; axis_next = axis_reg;
        prod_next = prod_reg; neg_next = neg_reg; res_c_next = res_c_reg;
        out_next = out_reg; ovalid_next = ovalid_reg;
        we = 1'b0; addr = '0; wdata = '0;
        dreq = '0;
        s_tready = 1'b0;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                we = 1'b1; addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = !ovalid_reg;
                if (s_tvalid && !ovalid_reg) begin
                    in_next = s_tdata;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (in_reg[0] == ACT_RECORD) begin
                    if (tg_ok) begin
                        we = 1'b1;
                        addr = AW'({tg, slot_reg[tg]});
                        wdata = in_s;
                    end
                    state_next = S_IDLE;
                end else if (!tg_ok || !seen_reg[tg]) begin
                    out_next = {190'd0, ST_UNSEEN};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    addr = AW'({tg, SW'(0)});
                    idx_next = (SW+1)'(1);
                    have_lo_next = 1'b0; have_hi_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // rdata holds slot idx_reg-1
                addr = AW'({tg, idx_reg[SW-1:0]});
                if (rdata.ts <= in_t && (!have_lo_reg || lot_reg < rdata.ts)) begin
                    lo_next = SW'(idx_reg - 1); lot_next = rdata.ts; have_lo_next = 1'b1;
                end
                if (rdata.ts >= in_t && (!have_hi_reg || hit_reg > rdata.ts)) begin
                    hi_next = SW'(idx_reg - 1); hit_next = rdata.ts; have_hi_next = 1'b1;
                end
                idx_next = idx_reg + (SW+1)'(1);
                if (idx_reg == (SW+1)'(DEPTH)) begin
                    state_next = S_FETCH_LO;
                end
            end
            S_FETCH_LO: begin
                if (!have_lo_reg || !have_hi_reg) begin
                    out_next = {190'd0, ST_NOBRKT};
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    addr = AW'({tg, lo_reg});
                    state_next = S_FETCH_HI;
                end
            end
            S_FETCH_HI: begin
                addr = AW'({tg, hi_reg});
                lo_s_next = rdata;
                state_next = S_LATCH;
            end
            S_LATCH: begin
                hi_s_next = rdata;
                axis_next = 2'd0;
                state_next = (hit_reg == lot_reg) ? S_OUT : S_MUL;
            end
            S_MUL: begin
                prod_next = 64'(mag[CTR_W-1:0]) * 64'(num);
                neg_next = diff[CTR_W];
                state_next = S_DIV;
            end
            S_DIV: begin
                dreq.start = 1'b1; dreq.num = prod_reg; dreq.den = den;
                state_next = S_NEXT_AXIS;
            end
            S_NEXT_AXIS: begin
                if (ddone) begin
                    res_c_next[axis_reg] = lo_c + off;
                    if (axis_reg == 2'd2) begin
                        state_next = S_OUT;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (hit_reg == lot_reg) begin
                    res_c_next[0] = lo_s_reg.cx;
                    res_c_next[1] = lo_s_reg.cy;
                    res_c_next[2] = lo_s_reg.cz;
                    out_next = {1'b0, lo_s_reg.ez, lo_s_reg.ey, lo_s_reg.ex,
                                lo_s_reg.cz, lo_s_reg.cy, lo_s_reg.cx, ST_OK};
                end else begin
                    out_next = {1'b0, lo_s_reg.ez, lo_s_reg.ey, lo_s_reg.ex,
                                res_c_reg[2], res_c_reg[1], res_c_reg[0], ST_OK};
                end
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            seen_reg <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < TARGETS; i++) begin
                slot_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            ovalid_reg <= ovalid_next;
            if (state_reg == S_READ && in_reg[0] == ACT_RECORD && tg_ok) begin
                seen_reg[tg] <= 1'b1;
                slot_reg[tg] <= (slot_reg[tg] == SW'(DEPTH - 1)) ? '0
                                                                 : slot_reg[tg] + SW'(1);
            end
        end
        in_reg <= in_next; idx_reg <= idx_next; lo_reg <= lo_next; hi_reg <= hi_next;
        lot_reg <= lot_next; hit_reg <= hit_next;
        have_lo_reg <= have_lo_next; have_hi_reg <= have_hi_next;
        lo_s_reg <= lo_s_next; hi_s_reg <= hi_s_next; axis_reg <= axis_next;
        prod_reg <= prod_next; neg_reg <= neg_next; res_c_reg <= res_c_next;
        out_reg <= out_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;
endmodule

// ===== design/tph_ram.sv =====
// ----------------------------------------------------------------------------
// tph_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/tph_div.sv =====
// ----------------------------------------------------------------------------
// tph_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module tph_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  tph_pkg::div_req_t req,
    output logic             done,
    output logic [63:0]      quot
);
    import tph_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        shifted = {r_reg[31:0], q_reg[63]};
        if (req.start) begin
            q_next = req.num; r_next = '0; d_next = req.den;
            cnt_next = 7'd64; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, d_reg}) begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== design/tph_checker.sv =====
// ----------------------------------------------------------------------------
// tph_checker
// Port-level checks for the position history block.
// ----------------------------------------------------------------------------
`include "timestamped_position_history_interp_macros.svh"

module tph_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [231:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);
    import tph_pkg::*;

    `TPH_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped while stalled")
    `TPH_ASSERT_IMPL(a_status, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "bad status code")
    `TPH_ASSERT_IMPL(a_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[191:2] == '0, "error word carries data")
    `TPH_ASSERT_IMPL(a_noready, aclk, aresetn, m_tvalid, !s_tready, "input taken while result pending")
endmodule

bind timestamped_position_history_interp tph_checker u_tph_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
